// ===== rtl/core/tpc_pkg.sv =====
// shared widths, codes and handshake types of the throttle position conditioner
`timescale 1ns / 1ps

package tpc_pkg;

   localparam int ADC_BITS  = 12;
   localparam int FRAC_BITS = 16;
   localparam int ACC_W     = ADC_BITS + FRAC_BITS;
   localparam int ALPHA_W   = 16;
   localparam int SPAN_W    = 12;
   localparam int PCT_W     = 14;

   // serial multiplier: one multiplier bit per cycle
   localparam int MPLIER_W  = 16;
   localparam int MUL_CNT_W = $clog2(MPLIER_W);
   localparam int PROD_W    = ACC_W + 1 + MPLIER_W + 1;

   // serial divider: one quotient bit per cycle
   localparam int DIV_CNT_W = $clog2(PCT_W);
   localparam int DVD_W     = ADC_BITS + PCT_W;

   localparam logic [ADC_BITS-1:0]  RAW_MAX    = {ADC_BITS{1'b1}};
   localparam logic [ADC_BITS-1:0]  RAIL_LOW   = ADC_BITS'(8);
   localparam logic [ADC_BITS-1:0]  RAIL_HIGH  = RAW_MAX - ADC_BITS'(8);
   localparam logic [PCT_W-1:0]     FULL_SCALE = PCT_W'(10000);
   localparam logic [MPLIER_W-1:0]  PCT_MULT   = MPLIER_W'(10000);
   localparam logic [ALPHA_W-1:0]   ALPHA_RST  = ALPHA_W'(6554);
   localparam logic [SPAN_W-1:0]    SPAN_RST   = SPAN_W'(100);

   // stream widths
   localparam int REQ_DATA_W = 16;
   localparam int REQ_USER_W = 2;
   localparam int RSP_FLDS_W = 4 * ADC_BITS + 3 + PCT_W;
   localparam int RSP_DATA_W = ((RSP_FLDS_W + 7) / 8) * 8;

   // csr
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] CSR_FILTER_ALPHA = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SPAN     = 1'b1;

   typedef enum logic [1:0] {
      CMD_SAMPLE  = 2'd0,
      CMD_CLOSED  = 2'd1,
      CMD_OPEN    = 2'd2,
      CMD_CLEAR   = 2'd3
   } command_type;

   typedef struct packed {
      logic                       start;
      logic signed [PROD_W-1:0]   mcand;
      logic [MPLIER_W-1:0]        mplier;
   } mul_req_type;

   typedef struct packed {
      logic                       done;
      logic signed [PROD_W-1:0]   product;
   } mul_rsp_type;

   typedef struct packed {
      logic                       start;
      logic [DVD_W-1:0]           dividend;
      logic [SPAN_W-1:0]          divisor;
   } div_req_type;

   typedef struct packed {
      logic                       done;
      logic [PCT_W-1:0]           quotient;
   } div_rsp_type;

endpackage

// ===== rtl/core/tpc_serial_mul.sv =====
// bit-serial signed by unsigned shift-add multiplier
`timescale 1ns / 1ps

module tpc_serial_mul
   import tpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mul_req,
   output mul_rsp_type mul_rsp
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [MUL_CNT_W-1:0]     cnt_ff, cnt_in;
   logic signed [PROD_W-1:0] mcand_ff, mcand_in;
   logic [MPLIER_W-1:0]      mplier_ff, mplier_in;
   logic signed [PROD_W-1:0] prod_ff, prod_in;

   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      prod_in   = prod_ff;
      if (mul_req.start) begin
         busy_in   = 1'b1;
         cnt_in    = MUL_CNT_W'(MPLIER_W - 1);
         mcand_in  = mul_req.mcand;
         mplier_in = mul_req.mplier;
         prod_in   = '0;
      end else if (busy_ff) begin
         if (mplier_ff[0]) begin
            prod_in = prod_ff + mcand_ff;
         end
         mcand_in  = mcand_ff <<< 1;
         mplier_in = mplier_ff >> 1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - MUL_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      prod_ff   <= prod_in;
   end

   assign mul_rsp.done    = done_ff;
   assign mul_rsp.product = prod_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      mul_req.start |=> busy_ff)
      else $error("multiplier did not start");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("multiplier done while busy");
   a_last_done: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !mul_req.start && cnt_ff == '0) |=> done_ff)
      else $error("multiplier missed its done pulse");

endmodule

// ===== rtl/core/tpc_serial_div.sv =====
// restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module tpc_serial_div
   import tpc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SPAN_W-1:0]     div_ff, div_in;
   logic [ADC_BITS-1:0]   rem_ff, rem_in;
   logic [PCT_W-1:0]      qsh_ff, qsh_in;
   logic [ADC_BITS:0]     trial;
   logic [ADC_BITS:0]     diff;
   logic                  fits;

   assign trial = {rem_ff, qsh_ff[PCT_W-1]};
   assign diff  = trial - {1'b0, div_ff};
   assign fits  = trial >= {1'b0, div_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      qsh_in  = qsh_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = DIV_CNT_W'(PCT_W - 1);
         div_in  = div_req.divisor;
         // upper part is already below the divisor, quotient fits PCT_W bits
         rem_in  = div_req.dividend[DVD_W-1:PCT_W];
         qsh_in  = div_req.dividend[PCT_W-1:0];
      end else if (busy_ff) begin
         rem_in = fits ? diff[ADC_BITS-1:0] : trial[ADC_BITS-1:0];
         qsh_in = {qsh_ff[PCT_W-2:0], fits};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - DIV_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      div_ff <= div_in;
      rem_ff <= rem_in;
      qsh_ff <= qsh_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = qsh_ff;

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (rem_ff < div_ff))
      else $error("partial remainder not below divisor");
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> busy_ff)
      else $error("divider did not start");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff)
      else $error("divider done while busy");

endmodule

// ===== rtl/core/throttle_position_conditioner.sv =====
// throttle position conditioner: ema filter, two-point calibration, percent output
//
//   channel  dir  handshake             payload
//   req      in   req_tvalid/tready     tuser: command; tdata: sample
//   rsp      out  rsp_tvalid/tready     tdata: raw, filtered, closed, open, flags, percent, ok
//   csr      in   csr_we                csr_index, csr_wdata
//
// captures and clear go straight to the finish step; a sample that seeds the filter
// skips the filter pass, any other sample runs it, and the percent is divided out only
// when the block is calibrated and the position lies strictly inside the span. each
// filter and percent product goes through the bit-serial multiplier, the quotient through the divider.
// synchronous reset clears the control and calibration state and loads the default register values.
// one request at a time; a new request is taken while a result still waits on rsp.
`timescale 1ns / 1ps

module throttle_position_conditioner
   import tpc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,   // [11:0] sample
   input  logic [REQ_USER_W-1:0]  req_tuser,   // [1:0] command
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // [11:0] raw_value, [23:12] filtered_value, [35:24] closed_point,
   // [47:36] open_point, [48] is_calibrated, [49] is_connected,
   // [63:50] percent_hundredths, [64] ok
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  logic                   csr_we,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILT_MUL,
      ST_PREP,
      ST_PCT_MUL,
      ST_PCT_DIV,
      ST_FINISH
   } state_type;

   state_type               state_ff, state_in;
   command_type             cmd_ff, cmd_in;
   logic [ALPHA_W-1:0]      alpha_ff, alpha_in;
   logic [SPAN_W-1:0]       min_span_ff, min_span_in;
   logic [ADC_BITS-1:0]     last_raw_ff, last_raw_in;
   logic [ACC_W-1:0]        acc_ff, acc_in;
   logic                    primed_ff, primed_in;
   logic [ADC_BITS-1:0]     closed_ff, closed_in;
   logic [ADC_BITS-1:0]     open_ff, open_in;
   logic                    connected_ff, connected_in;
   logic [PCT_W-1:0]        pct_ff, pct_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]   rsp_data_ff, rsp_data_in;
   mul_req_type             mul_req_ff, mul_req_in;
   div_req_type             div_req_ff, div_req_in;
   mul_rsp_type             mul_rsp;
   div_rsp_type             div_rsp;

   logic                    req_accept;
   command_type             req_cmd;
   logic [ADC_BITS-1:0]     req_raw;
   logic signed [ACC_W:0]   diff;
   logic signed [PROD_W-1:0] rnd_prod;
   logic [ADC_BITS:0]       rnd_sum;
   logic [ADC_BITS-1:0]     rnd_val;
   logic [SPAN_W-1:0]       span;
   logic                    is_cal;
   logic [ACC_W-1:0]        c_full;
   logic [ACC_W-1:0]        den;
   logic [ACC_W-1:0]        num;
   logic                    ok;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign req_cmd    = command_type'(req_tuser[1:0]);
   assign req_raw    = req_tdata[ADC_BITS-1:0];

   // filter error term, target minus accumulator
   assign diff = $signed({1'b0, req_raw, {FRAC_BITS{1'b0}}}) - $signed({1'b0, acc_ff});

   // round alpha * error to nearest, halves up
   assign rnd_prod = mul_rsp.product + $signed(PROD_W'(1) << (ALPHA_W - 1));

   assign rnd_sum = {1'b0, acc_ff[ACC_W-1:FRAC_BITS]} + (ADC_BITS + 1)'(acc_ff[FRAC_BITS-1]);
   assign rnd_val = rnd_sum[ADC_BITS] ? RAW_MAX : rnd_sum[ADC_BITS-1:0];

   assign span   = (open_ff >= closed_ff) ? (open_ff - closed_ff) : (closed_ff - open_ff);
   assign is_cal = span >= min_span_ff;
   assign c_full = {closed_ff, {FRAC_BITS{1'b0}}};
   assign den    = {span, {FRAC_BITS{1'b0}}};
   assign ok     = !((cmd_ff == CMD_OPEN) && !is_cal);

   always_comb begin
      num = '0;
      if ((open_ff > closed_ff) && (acc_ff > c_full)) begin
         num = acc_ff - c_full;
      end else if ((closed_ff > open_ff) && (acc_ff < c_full)) begin
         num = c_full - acc_ff;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      alpha_in     = alpha_ff;
      min_span_in  = min_span_ff;
      last_raw_in  = last_raw_ff;
      acc_in       = acc_ff;
      primed_in    = primed_ff;
      closed_in    = closed_ff;
      open_in      = open_ff;
      connected_in = connected_ff;
      pct_in       = pct_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      mul_req_in   = mul_req_ff;
      div_req_in   = div_req_ff;
      mul_req_in.start = 1'b0;
      div_req_in.start = 1'b0;

      if (csr_we) begin
         case (csr_index)
            CSR_FILTER_ALPHA: alpha_in    = csr_wdata[ALPHA_W-1:0];
            CSR_MIN_SPAN:     min_span_in = csr_wdata[SPAN_W-1:0];
            default:          alpha_in    = alpha_ff;
         endcase
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in = req_cmd;
               case (req_cmd)
                  CMD_SAMPLE: begin
                     last_raw_in  = req_raw;
                     connected_in = (req_raw > RAIL_LOW) && (req_raw < RAIL_HIGH);
                     if (primed_ff) begin
                        mul_req_in.start  = 1'b1;
                        mul_req_in.mcand  = {{(PROD_W-ACC_W-1){diff[ACC_W]}}, diff};
                        mul_req_in.mplier = MPLIER_W'(alpha_ff);
                        state_in = ST_FILT_MUL;
                     end else begin
                        // first sample seeds the filter
                        acc_in    = {req_raw, {FRAC_BITS{1'b0}}};
                        primed_in = 1'b1;
                        state_in  = ST_PREP;
                     end
                  end
                  CMD_CLOSED: begin
                     closed_in = rnd_val;
                     state_in  = ST_FINISH;
                  end
                  CMD_OPEN: begin
                     open_in  = rnd_val;
                     state_in = ST_FINISH;
                  end
                  CMD_CLEAR: begin
                     closed_in = '0;
                     open_in   = '0;
                     pct_in    = '0;
                     state_in  = ST_FINISH;
                  end
                  default: state_in = ST_FINISH;
               endcase
            end
         end
         ST_FILT_MUL: begin
            if (mul_rsp.done) begin
               acc_in   = acc_ff + rnd_prod[ACC_W+ALPHA_W-1:ALPHA_W];
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            if (!is_cal || (num == '0)) begin
               pct_in   = '0;
               state_in = ST_FINISH;
            end else if (num >= den) begin
               pct_in   = FULL_SCALE;
               state_in = ST_FINISH;
            end else begin
               mul_req_in.start  = 1'b1;
               mul_req_in.mcand  = $signed(PROD_W'(num));
               mul_req_in.mplier = PCT_MULT;
               state_in = ST_PCT_MUL;
            end
         end
         ST_PCT_MUL: begin
            if (mul_rsp.done) begin
               // floor(floor(m / 2^F) / span) equals floor(m / (span * 2^F))
               div_req_in.start    = 1'b1;
               div_req_in.dividend = mul_rsp.product[FRAC_BITS+DVD_W-1:FRAC_BITS];
               div_req_in.divisor  = span;
               state_in = ST_PCT_DIV;
            end
         end
         ST_PCT_DIV: begin
            if (div_rsp.done) begin
               pct_in   = div_rsp.quotient;
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_DATA_W-RSP_FLDS_W){1'b0}}, ok, pct_ff, connected_ff,
                               is_cal, open_ff, closed_ff, rnd_val, last_raw_ff};
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         cmd_ff           <= CMD_SAMPLE;
         alpha_ff         <= ALPHA_RST;
         min_span_ff      <= SPAN_RST;
         last_raw_ff      <= '0;
         acc_ff           <= '0;
         primed_ff        <= 1'b0;
         closed_ff        <= '0;
         open_ff          <= '0;
         connected_ff     <= 1'b0;
         pct_ff           <= '0;
         rsp_valid_ff     <= 1'b0;
         mul_req_ff.start <= 1'b0;
         div_req_ff.start <= 1'b0;
      end else begin
         state_ff         <= state_in;
         cmd_ff           <= cmd_in;
         alpha_ff         <= alpha_in;
         min_span_ff      <= min_span_in;
         last_raw_ff      <= last_raw_in;
         acc_ff           <= acc_in;
         primed_ff        <= primed_in;
         closed_ff        <= closed_in;
         open_ff          <= open_in;
         connected_ff     <= connected_in;
         pct_ff           <= pct_in;
         rsp_valid_ff     <= rsp_valid_in;
         mul_req_ff.start <= mul_req_in.start;
         div_req_ff.start <= div_req_in.start;
      end
      rsp_data_ff         <= rsp_data_in;
      mul_req_ff.mcand    <= mul_req_in.mcand;
      mul_req_ff.mplier   <= mul_req_in.mplier;
      div_req_ff.dividend <= div_req_in.dividend;
      div_req_ff.divisor  <= div_req_in.divisor;
   end

   tpc_serial_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req_ff),
      .mul_rsp (mul_rsp)
   );

   tpc_serial_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req_ff),
      .div_rsp (div_rsp)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_pct_bound: assert property (@(posedge clock) disable iff (reset)
      pct_ff <= FULL_SCALE)
      else $error("percent above full scale");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> (state_ff != ST_IDLE))
      else $error("request accepted but no work started");
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("result raised outside finish");
   a_div_only_pct: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ST_PCT_DIV))
      else $error("divider finished outside percent step");

endmodule

// ===== dv/throttle_position_conditioner_test.sv =====
// self-checking stream testbench for the throttle position conditioner
`timescale 1ns / 1ps

module throttle_position_conditioner_test;
   import tpc_pkg::*;

   localparam int DIRECTED_N  = 25;
   localparam int PHASES      = 8;
   localparam int PHASE_ITEMS = 92;
   localparam int IDLE_LIMIT  = 2000;
   localparam int TAIL_CYCLES = 80;

   typedef struct packed {
      logic [ADC_BITS-1:0] raw;
      logic [ADC_BITS-1:0] filtered;
      logic [ADC_BITS-1:0] closed_pt;
      logic [ADC_BITS-1:0] open_pt;
      logic                calibrated;
      logic                connected;
      logic [PCT_W-1:0]    percent;
      logic                ok;
   } reading_type;

   typedef struct packed {
      command_type         cmd;
      logic [ADC_BITS-1:0] sample;
      logic                known;
      reading_type         want;
   } step_row_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic [REQ_USER_W-1:0] req_tuser  = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   // predicted block state
   logic [ALPHA_W-1:0]    alpha_q     = ALPHA_RST;
   logic [SPAN_W-1:0]     span_q      = SPAN_RST;
   logic [ADC_BITS-1:0]   raw_q       = '0;
   longint                acc_q       = 0;
   bit                    seeded_q    = 1'b0;
   logic [ADC_BITS-1:0]   closed_q    = '0;
   logic [ADC_BITS-1:0]   open_q      = '0;
   bit                    connected_q = 1'b0;
   logic [PCT_W-1:0]      percent_q   = '0;

   reading_type           pending_readings[$];
   reading_type           want_reading;
   reading_type           got_reading;
   int                    fail_count        = 0;
   int                    accepted_requests = 0;
   int                    idle_cycles       = 0;
   int                    stall_left        = 0;
   bit                    quiet             = 1'b0;

   // fields: raw, filtered, closed, open, calibrated, connected, percent, ok
   step_row_type directed_rows [0:DIRECTED_N-1] = '{
      '{CMD_CLOSED, 12'hFFF, 1'b1, '{12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 14'd0, 1'b1}},
      '{CMD_OPEN,   12'h000, 1'b1, '{12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 14'd0, 1'b0}},
      '{CMD_CLEAR,  12'hABC, 1'b1, '{12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0, 14'd0, 1'b1}},
      // first sample seeds the filter straight to the reading
      '{CMD_SAMPLE, 12'd4095, 1'b1,
        '{12'd4095, 12'd4095, 12'd0, 12'd0, 1'b0, 1'b0, 14'd0, 1'b1}},
      '{CMD_OPEN,   12'h555, 1'b1,
        '{12'd4095, 12'd4095, 12'd0, 12'd4095, 1'b1, 1'b0, 14'd0, 1'b1}},
      '{CMD_SAMPLE, 12'd4095, 1'b1,
        '{12'd4095, 12'd4095, 12'd0, 12'd4095, 1'b1, 1'b0, 14'd10000, 1'b1}},
      '{CMD_SAMPLE, 12'd0,    1'b0, '0},
      '{CMD_SAMPLE, 12'd8,    1'b0, '0},
      '{CMD_SAMPLE, 12'd9,    1'b0, '0},
      '{CMD_SAMPLE, 12'd4086, 1'b0, '0},
      '{CMD_SAMPLE, 12'd4087, 1'b0, '0},
      '{CMD_SAMPLE, 12'hAAA,  1'b0, '0},
      '{CMD_SAMPLE, 12'h555,  1'b0, '0},
      '{CMD_CLOSED, 12'd0,    1'b0, '0},
      // drag the filter down so open lands below closed
      '{CMD_SAMPLE, 12'd0,    1'b0, '0},
      '{CMD_SAMPLE, 12'd0,    1'b0, '0},
      '{CMD_SAMPLE, 12'd0,    1'b0, '0},
      '{CMD_OPEN,   12'd0,    1'b0, '0},
      '{CMD_SAMPLE, 12'd2048, 1'b0, '0},
      '{CMD_SAMPLE, 12'd4095, 1'b0, '0},
      '{CMD_CLEAR,  12'd0,    1'b0, '0},
      '{CMD_SAMPLE, 12'd1000, 1'b0, '0},
      // both points equal: zero span
      '{CMD_CLOSED, 12'd0,    1'b0, '0},
      '{CMD_OPEN,   12'd0,    1'b0, '0},
      '{CMD_SAMPLE, 12'd1000, 1'b0, '0}
   };

   always #6 clock = ~clock;

   throttle_position_conditioner u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   function automatic logic [ADC_BITS-1:0] filtered_count();
      longint v;
      v = (acc_q + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (v > longint'(RAW_MAX)) v = longint'(RAW_MAX);
      return v[ADC_BITS-1:0];
   endfunction

   function automatic bit span_reached();
      logic [ADC_BITS-1:0] span;
      span = (open_q >= closed_q) ? open_q - closed_q : closed_q - open_q;
      return span >= span_q;
   endfunction

   // opening measured from closed toward open, either direction
   function automatic logic [PCT_W-1:0] opening_hundredths();
      longint c, o, num, den, q;
      c = longint'(closed_q) <<< FRAC_BITS;
      o = longint'(open_q) <<< FRAC_BITS;
      if (o > c) begin
         if (acc_q <= c) return '0;
         num = acc_q - c;
         den = o - c;
      end else if (c > o) begin
         if (acc_q >= c) return '0;
         num = c - acc_q;
         den = c - o;
      end else begin
         return '0;
      end
      q = num * longint'(FULL_SCALE) / den;
      if (q > longint'(FULL_SCALE)) q = longint'(FULL_SCALE);
      return q[PCT_W-1:0];
   endfunction

   function automatic reading_type predict_reading(command_type cmd,
                                                   logic [ADC_BITS-1:0] smp);
      reading_type r;
      longint t;
      r.ok = 1'b1;
      case (cmd)
         CMD_SAMPLE: begin
            raw_q = smp;
            if (!seeded_q) begin
               acc_q    = longint'(smp) <<< FRAC_BITS;
               seeded_q = 1'b1;
            end else begin
               // alpha times the error, rounded half up, floor on the way down
               t = longint'(alpha_q) * ((longint'(smp) <<< FRAC_BITS) - acc_q) + 32768;
               acc_q = acc_q + (t >>> ALPHA_W);
            end
            connected_q = smp > RAIL_LOW && smp < RAIL_HIGH;
            percent_q   = span_reached() ? opening_hundredths() : '0;
         end
         CMD_CLOSED: begin
            closed_q = filtered_count();
         end
         CMD_OPEN: begin
            open_q = filtered_count();
            r.ok   = span_reached();
         end
         default: begin
            closed_q  = '0;
            open_q    = '0;
            percent_q = '0;
         end
      endcase
      r.raw        = raw_q;
      r.filtered   = filtered_count();
      r.closed_pt  = closed_q;
      r.open_pt    = open_q;
      r.calibrated = span_reached();
      r.connected  = connected_q;
      r.percent    = percent_q;
      return r;
   endfunction

   function automatic logic [ADC_BITS-1:0] near_level(int level);
      int v;
      v = level + int'($urandom_range(0, 30)) - 15;
      if (v < 0) v = 0;
      if (v > 4095) v = 4095;
      return v[ADC_BITS-1:0];
   endfunction

   task automatic check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   task automatic send_request(command_type cmd, logic [ADC_BITS-1:0] smp,
                               bit known = 1'b0, reading_type want = '0);
      int gap;
      reading_type predicted;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= REQ_DATA_W'(smp);
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = predict_reading(cmd, smp);
      pending_readings.push_back(known ? want : predicted);
      accepted_requests++;
      @(negedge clock);
   endtask

   task automatic wait_results();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (pending_readings.size() != 0);
   endtask

   task automatic load_settings(logic [ALPHA_W-1:0] alpha, logic [SPAN_W-1:0] span);
      csr_we    <= 1'b1;
      csr_index <= CSR_FILTER_ALPHA;
      csr_wdata <= CSR_DATA_W'(alpha);
      @(negedge clock);
      csr_index <= CSR_MIN_SPAN;
      csr_wdata <= CSR_DATA_W'(span);
      @(negedge clock);
      csr_we    <= 1'b0;
      alpha_q = alpha;
      span_q  = span;
   endtask

   // response backpressure
   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            $error("result with no request outstanding: %h", rsp_tdata);
            fail_count++;
         end else begin
            want_reading           = pending_readings.pop_front();
            got_reading.raw        = rsp_tdata[11:0];
            got_reading.filtered   = rsp_tdata[23:12];
            got_reading.closed_pt  = rsp_tdata[35:24];
            got_reading.open_pt    = rsp_tdata[47:36];
            got_reading.calibrated = rsp_tdata[48];
            got_reading.connected  = rsp_tdata[49];
            got_reading.percent    = rsp_tdata[63:50];
            got_reading.ok         = rsp_tdata[64];
            check_field("raw_value", 32'(want_reading.raw), 32'(got_reading.raw));
            check_field("filtered_value", 32'(want_reading.filtered),
                        32'(got_reading.filtered));
            check_field("closed_point", 32'(want_reading.closed_pt),
                        32'(got_reading.closed_pt));
            check_field("open_point", 32'(want_reading.open_pt),
                        32'(got_reading.open_pt));
            check_field("is_calibrated", 32'(want_reading.calibrated),
                        32'(got_reading.calibrated));
            check_field("is_connected", 32'(want_reading.connected),
                        32'(got_reading.connected));
            check_field("percent_hundredths", 32'(want_reading.percent),
                        32'(got_reading.percent));
            check_field("ok", 32'(want_reading.ok), 32'(got_reading.ok));
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("throttle_position_conditioner test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int lo, hi, swap_tmp, n, target;
      logic [ALPHA_W-1:0] alpha;
      logic [SPAN_W-1:0] span;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         send_request(directed_rows[i].cmd, directed_rows[i].sample,
                      directed_rows[i].known, directed_rows[i].want);
      end

      for (int phase = 0; phase < PHASES; phase++) begin
         wait_results();
         case (phase)
            0: begin alpha = 16'hFFFF; span = 12'hFFF; end
            1: begin alpha = 16'd1; span = 12'd1; end
            2: begin alpha = ALPHA_RST; span = SPAN_RST; end
            // zero span threshold: always calibrated, even with equal points
            3: begin alpha = ALPHA_W'($urandom_range(1, 65535)); span = '0; end
            4: begin alpha = 16'h8000; span = 12'd1; end
            6: begin alpha = 16'hFFFF; span = 12'd1; end
            default: begin
               alpha = ALPHA_W'($urandom_range(1, 65535));
               span  = SPAN_W'($urandom_range(1, 4095));
            end
         endcase
         load_settings(alpha, span);
         quiet  = (phase % 3 == 2);
         target = accepted_requests + PHASE_ITEMS;
         while (accepted_requests < target) begin
            if ($urandom_range(0, 4) != 0) begin
               // calibrate on two levels, then sweep samples across them
               lo = $urandom_range(0, 1500);
               hi = $urandom_range(2500, 4095);
               if ($urandom_range(0, 9) < 3) begin
                  swap_tmp = lo;
                  lo       = hi;
                  hi       = swap_tmp;
               end
               n = $urandom_range(2, 12);
               repeat (n) send_request(CMD_SAMPLE, near_level(lo));
               send_request(CMD_CLOSED, ADC_BITS'($urandom_range(0, 4095)));
               n = $urandom_range(2, 12);
               repeat (n) send_request(CMD_SAMPLE, near_level(hi));
               send_request(CMD_OPEN, ADC_BITS'($urandom_range(0, 4095)));
               n = $urandom_range(4, 20);
               repeat (n) begin
                  if ($urandom_range(0, 1) == 0)
                     send_request(CMD_SAMPLE, ADC_BITS'($urandom_range(0, 4095)));
                  else
                     send_request(CMD_SAMPLE, ADC_BITS'($urandom_range(lo, hi)));
               end
               if ($urandom_range(0, 9) == 0)
                  send_request(CMD_CLEAR, ADC_BITS'($urandom_range(0, 4095)));
            end else begin
               n = $urandom_range(1, 8);
               repeat (n) send_request(command_type'($urandom_range(0, 3)),
                                       ADC_BITS'($urandom_range(0, 4095)));
            end
            if ($urandom_range(0, 19) == 0) wait_results();
         end
      end

      wait_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("throttle_position_conditioner test passed");
      else
         $display("throttle_position_conditioner test failed");
      $finish;
   end

endmodule
